@@ design/sorted_table_insert_delete_top_defines.svh @@
// ============================================================================
// Assertion macros for the sorted table
// Each macro wraps one concurrent assertion. Synthesis builds leave it empty.
// ============================================================================
`ifndef SORTED_TABLE_INSERT_DELETE_TOP_DEFINES_SVH
`define SORTED_TABLE_INSERT_DELETE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// This assertion is checked at every rising clock edge and is not checked while in reset.
`define STID_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// This assertion is checked at every rising clock edge, during reset too.
`define STID_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define STID_ASSERT(label, clk, rst, prop, msg)
`define STID_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ design/stid_pkg.sv @@
// ============================================================================
// Sorted table package
// Sizes, codes and the structs that are passed between the sorted table modules.
// ============================================================================
package stid_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int POS_W       = 4;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_READ_OUT = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_ENTRY     = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      op_type                        operation;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      status_type                    status;
      logic signed [VALUE_WIDTH-1:0] entry_value;
      logic [POS_W-1:0]              position;
      logic                          last;
   } rsp_type;

   // Register file access for one cycle: one write and one read.
   typedef struct packed {
      logic                          wr_en;
      logic [IDX_W-1:0]              wr_addr;
      logic signed [VALUE_WIDTH-1:0] wr_data;
      logic [IDX_W-1:0]              rd_addr;
   } rf_ctrl_type;

   // Flags from the shared comparator.
   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_flags_type;

endpackage

@@ design/stid_regfile.sv @@
// ============================================================================
// Sorted table register file
// Holds the table entries, with one write port and one read port.
// ============================================================================
module stid_regfile (
   input  logic                                   clock,
   input  stid_pkg::rf_ctrl_type                  rf_ctrl,
   output logic signed [stid_pkg::VALUE_WIDTH-1:0] rd_data
);

   logic signed [stid_pkg::VALUE_WIDTH-1:0] entry_ff [stid_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (rf_ctrl.wr_en) begin
         entry_ff[rf_ctrl.wr_addr] <= rf_ctrl.wr_data;
      end
   end

   assign rd_data = entry_ff[rf_ctrl.rd_addr];

endmodule

@@ design/stid_cmp.sv @@
// ============================================================================
// Sorted table comparator
// The one signed compare unit that the insert and remove scans use.
// ============================================================================
module stid_cmp (
   input  logic signed [stid_pkg::VALUE_WIDTH-1:0] a,
   input  logic signed [stid_pkg::VALUE_WIDTH-1:0] b,
   output stid_pkg::cmp_flags_type                 flags
);

   assign flags.gt = (a > b);
   assign flags.eq = (a == b);

endmodule

@@ design/stid_ctrl.sv @@
// ============================================================================
// Sorted table sequencer
// Walks the table one entry a cycle to insert, remove or read out; clear zeroes the entry count.
// ============================================================================
`include "sorted_table_insert_delete_top_defines.svh"

module stid_ctrl (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  stid_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   output stid_pkg::rsp_type                       rsp_data,
   output stid_pkg::rf_ctrl_type                   rf_ctrl,
   input  logic signed [stid_pkg::VALUE_WIDTH-1:0] rd_data,
   output logic signed [stid_pkg::VALUE_WIDTH-1:0] cmp_operand,
   input  stid_pkg::cmp_flags_type                 cmp_flags
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_REM_SEARCH,
      S_REM_SHIFT,
      S_READ_OUT
   } state_type;

   localparam logic [stid_pkg::CNT_W-1:0] FULL_COUNT = stid_pkg::CNT_W'(stid_pkg::TABLE_DEPTH);
   localparam logic [stid_pkg::CNT_W-1:0] ONE        = stid_pkg::CNT_W'(1);
   localparam logic [stid_pkg::CNT_W-1:0] TWO        = stid_pkg::CNT_W'(2);

   state_type                               state_ff, state_in;
   logic [stid_pkg::CNT_W-1:0]              idx_ff, idx_in;
   logic [stid_pkg::CNT_W-1:0]              count_ff, count_in;
   logic [stid_pkg::CNT_W-1:0]              pos_ff, pos_in;
   logic signed [stid_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   stid_pkg::rsp_type                       rsp_ff, rsp_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rf_ctrl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in = req_data.value;
               idx_in   = '0;
               unique case (req_data.operation)
                  stid_pkg::OP_INSERT: begin
                     if (count_ff == FULL_COUNT) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{stid_pkg::ST_FULL, '0, '0, 1'b1};
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INSERT;
                     end
                  end
                  stid_pkg::OP_REMOVE: begin
                     state_in = S_REM_SEARCH;
                  end
                  stid_pkg::OP_READ_OUT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{stid_pkg::ST_EMPTY, '0, '0, 1'b1};
                     end else begin
                        state_in = S_READ_OUT;
                     end
                  end
                  stid_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{stid_pkg::ST_DONE, '0, '0, 1'b1};
                  end
               endcase
            end
         end
         S_INSERT: begin
            // Entries above the new value move up by one until its slot is found.
            rf_ctrl.rd_addr = stid_pkg::IDX_W'(idx_ff - ONE);
            rf_ctrl.wr_en   = 1'b1;
            rf_ctrl.wr_addr = stid_pkg::IDX_W'(idx_ff);
            if ((idx_ff == '0) || !cmp_flags.gt) begin
               rf_ctrl.wr_data = value_ff;
               count_in        = count_ff + ONE;
               rsp_valid_in    = 1'b1;
               rsp_in          = '{stid_pkg::ST_DONE, '0, stid_pkg::POS_W'(idx_ff), 1'b1};
               state_in        = S_IDLE;
            end else begin
               rf_ctrl.wr_data = rd_data;
               idx_in          = idx_ff - ONE;
            end
         end
         S_REM_SEARCH: begin
            rf_ctrl.rd_addr = stid_pkg::IDX_W'(idx_ff);
            if (idx_ff == count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{stid_pkg::ST_NOT_FOUND, '0, '0, 1'b1};
               state_in     = S_IDLE;
            end else if (cmp_flags.eq) begin
               pos_in = idx_ff;
               if (idx_ff + ONE == count_ff) begin
                  count_in     = count_ff - ONE;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{stid_pkg::ST_DONE, '0, stid_pkg::POS_W'(idx_ff), 1'b1};
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_REM_SHIFT;
               end
            end else begin
               idx_in = idx_ff + ONE;
            end
         end
         S_REM_SHIFT: begin
            // Entries above the removed one move down by one.
            rf_ctrl.rd_addr = stid_pkg::IDX_W'(idx_ff + ONE);
            rf_ctrl.wr_en   = 1'b1;
            rf_ctrl.wr_addr = stid_pkg::IDX_W'(idx_ff);
            rf_ctrl.wr_data = rd_data;
            idx_in          = idx_ff + ONE;
            if (idx_ff + TWO == count_ff) begin
               count_in     = count_ff - ONE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{stid_pkg::ST_DONE, '0, stid_pkg::POS_W'(pos_ff), 1'b1};
               state_in     = S_IDLE;
            end
         end
         S_READ_OUT: begin
            rf_ctrl.rd_addr = stid_pkg::IDX_W'(idx_ff);
            rsp_valid_in    = 1'b1;
            rsp_in.status      = stid_pkg::ST_ENTRY;
            rsp_in.entry_value = rd_data;
            rsp_in.position    = stid_pkg::POS_W'(idx_ff);
            rsp_in.last        = (idx_ff + ONE == count_ff);
            idx_in             = idx_ff + ONE;
            if (idx_ff + ONE == count_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign cmp_operand = value_ff;

   `STID_ASSERT(a_count_bound, clock, reset, count_ff <= FULL_COUNT, "entry count above depth")
   `STID_ASSERT(a_accept_acts, clock, reset, (start && !busy) |=> (busy || rsp_valid), "request dropped")
   `STID_ASSERT(a_last_ends, clock, reset, (rsp_valid_ff && rsp_ff.last) |-> (state_ff == S_IDLE), "busy after last result")
   `STID_ASSERT(a_more_follows, clock, reset, (rsp_valid_ff && !rsp_ff.last) |-> (state_ff == S_READ_OUT), "stream cut short")
   `STID_ASSERT(a_idle_no_write, clock, reset, (state_ff == S_IDLE) |-> !rf_ctrl.wr_en, "table written while idle")

endmodule

@@ design/sorted_table_insert_delete_top.sv @@
// ============================================================================
// Sorted table with insert, remove, read-out and clear
// Keeps signed values in ascending order and answers one request at a time.
// ============================================================================
// Clear, full insert and empty read-out answer from idle; insert moves each entry above the
// slot up by one, then writes the value; remove scans up to the match (every entry
// when absent), then moves each entry above it down by one; read-out streams the entries from
// the bottom, one a cycle. Throughput: one request at a time, as the sequencer steps over the
// single register file read port; busy stays high until the final result is on the ports.
// Reset (synchronous, active high) empties the table; entries are not cleared.
// ============================================================================
module sorted_table_insert_delete_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  stid_pkg::req_type req_data,
   output logic              rsp_valid,
   output stid_pkg::rsp_type rsp_data
);

   // The sequencer drives one read and at most one write of the register file in each cycle.
   stid_pkg::rf_ctrl_type                   rf_ctrl;
   logic signed [stid_pkg::VALUE_WIDTH-1:0] rd_data;

   // The comparator checks the entry that was read against the value of the request.
   logic signed [stid_pkg::VALUE_WIDTH-1:0] cmp_operand;
   stid_pkg::cmp_flags_type                 cmp_flags;

   // The sequencer accepts the request, walks the table and builds every result.
   // The receiver cannot stall: each result is shown for exactly one cycle on rsp_valid.
   stid_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rf_ctrl     (rf_ctrl),
      .rd_data     (rd_data),
      .cmp_operand (cmp_operand),
      .cmp_flags   (cmp_flags)
   );

   // The register file holds the sorted entries below the entry count.
   stid_regfile u_regfile (
      .clock   (clock),
      .rf_ctrl (rf_ctrl),
      .rd_data (rd_data)
   );

   // The single compare unit serves both the insert slot search and the remove match.
   stid_cmp u_cmp (
      .a     (rd_data),
      .b     (cmp_operand),
      .flags (cmp_flags)
   );

endmodule

@@ tb/sv/stid_table_checker.sv @@
// ============================================================================
// Sorted table result checker
// Tracks the table contents from every accepted request and compares each
// result strobe, field by field, with the oldest result still awaited.
// ============================================================================
module stid_table_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  stid_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  stid_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [stid_pkg::VALUE_WIDTH-1:0] shadow_entries [stid_pkg::TABLE_DEPTH];
   int                                      shadow_count;
   stid_pkg::rsp_type                       awaited_results [$];

   function automatic stid_pkg::rsp_type make_result(stid_pkg::status_type st,
                                                     logic signed [stid_pkg::VALUE_WIDTH-1:0] val,
                                                     int pos, logic fin);
      stid_pkg::rsp_type r;
      r.status      = st;
      r.entry_value = val;
      r.position    = stid_pkg::POS_W'(pos);
      r.last        = fin;
      return r;
   endfunction

   // Applies one request to the tracked table and queues the results it causes.
   task automatic apply_request(stid_pkg::req_type req);
      logic signed [stid_pkg::VALUE_WIDTH-1:0] val;
      int                                      slot;
      int                                      i;
      val = req.value;
      case (req.operation)
         stid_pkg::OP_INSERT: begin
            if (shadow_count >= stid_pkg::TABLE_DEPTH) begin
               awaited_results.push_back(make_result(stid_pkg::ST_FULL, '0, 0, 1'b1));
            end else begin
               // Equal values go behind the ones already stored.
               slot = 0;
               while (slot < shadow_count && shadow_entries[slot] <= val) slot++;
               for (i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[slot] = val;
               shadow_count++;
               awaited_results.push_back(make_result(stid_pkg::ST_DONE, '0, slot, 1'b1));
            end
         end
         stid_pkg::OP_REMOVE: begin
            slot = 0;
            while (slot < shadow_count && shadow_entries[slot] != val) slot++;
            if (slot >= shadow_count) begin
               awaited_results.push_back(make_result(stid_pkg::ST_NOT_FOUND, '0, 0, 1'b1));
            end else begin
               for (i = slot; i < shadow_count - 1; i++) shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
               awaited_results.push_back(make_result(stid_pkg::ST_DONE, '0, slot, 1'b1));
            end
         end
         stid_pkg::OP_READ_OUT: begin
            if (shadow_count == 0) begin
               awaited_results.push_back(make_result(stid_pkg::ST_EMPTY, '0, 0, 1'b1));
            end else begin
               for (i = 0; i < shadow_count; i++)
                  awaited_results.push_back(make_result(stid_pkg::ST_ENTRY, shadow_entries[i],
                                                        i, i == shadow_count - 1));
            end
         end
         default: begin
            shadow_count = 0;
            awaited_results.push_back(make_result(stid_pkg::ST_DONE, '0, 0, 1'b1));
         end
      endcase
   endtask

   always @(posedge clock) begin
      stid_pkg::rsp_type want;
      if (reset) begin
         fail_count   = 0;
         shadow_count = 0;
         awaited_results.delete();
      end else begin
         // A result retires before a request taken at the same edge is applied.
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               $error("result with none awaited: status %0d, entry_value %0d, position %0d",
                      rsp_data.status, rsp_data.entry_value, rsp_data.position);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.entry_value !== want.entry_value) begin
                  $error("entry_value: expected %0d, actual %0d", want.entry_value,
                         rsp_data.entry_value);
                  fail_count++;
               end
               if (rsp_data.position !== want.position) begin
                  $error("position: expected %0d, actual %0d", want.position,
                         rsp_data.position);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) apply_request(req_data);
      end
      pending <= awaited_results.size();
   end

endmodule

@@ tb/sv/tb_sorted_table_insert_delete_top.sv @@
// ============================================================================
// Sorted table testbench
// Drives directed and random insert, remove, read-out and clear requests into
// the sorted table, with random gaps between them, and reports the verdict
// from the checker's failure count.
// ============================================================================
module tb_sorted_table_insert_delete_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   stid_pkg::req_type req_data = '0;
   logic              busy;
   logic              rsp_valid;
   stid_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending;

   // When clear, requests follow one another with no gaps at all.
   bit                 idle_on = 1'b1;
   // Values inserted lately, so that many removes find a match.
   logic signed [31:0] recent_values [$];

   always #1 clock = ~clock;

   sorted_table_insert_delete_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   stid_table_checker u_table_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // This bound is only reached if the block hangs.
   initial begin
      #500_000;
      $display("Test completed with failures");
      $finish;
   end

   // Small values in four of ten picks, so that duplicates and matching removes are common,
   // the extremes in one and fully random words in the rest.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed(32'($urandom_range(0, 6))) - 32'sd3;
         4: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7FFF_FFFF;
               2:       return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Presents one request at the falling edge and holds it until busy is low after a rising
   // edge; the block takes it at the first rising edge at which busy is low.
   task automatic issue(input stid_pkg::op_type op, input logic signed [31:0] value);
      int gap;
      if (idle_on && $urandom_range(0, 99) < 17) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
         @(negedge clock);
         start              <= 1'b0;
         req_data.operation <= stid_pkg::op_type'($urandom_range(0, 3));
         req_data.value     <= $urandom;
         repeat (gap) @(negedge clock);
      end
      @(negedge clock);
      start              <= 1'b1;
      req_data.operation <= op;
      req_data.value     <= value;
      do @(posedge clock); while (busy);
      if (op == stid_pkg::OP_INSERT) begin
         recent_values.push_back(value);
         if (recent_values.size() > 24) void'(recent_values.pop_front());
      end
   endtask

   initial begin
      logic signed [31:0] fill_values [16];
      int                 n;
      int                 roll;
      bit                 filling;
      logic signed [31:0] value;

      fill_values = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd0, 32'sd1,
                      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh8000_0000, 32'sh7FFF_FFFF,
                      32'sd100, -32'sd100, 32'sd7, -32'sd7, 32'sh0F0F_0F0F, 32'sh70F0_F0F0};

      // Synchronous reset is held from the start and released at a falling edge.
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed part. An empty table must report table empty on read-out and
      // not found on remove.
      issue(stid_pkg::OP_READ_OUT, 32'sd0);
      issue(stid_pkg::OP_REMOVE, 32'sd5);
      // Fill the table with the extremes and duplicates, so that equal values
      // must keep their arrival order.
      foreach (fill_values[i]) issue(stid_pkg::OP_INSERT, fill_values[i]);
      // Inserting into a full table must report full and leave it unchanged.
      issue(stid_pkg::OP_INSERT, 32'sd42);
      issue(stid_pkg::OP_READ_OUT, $urandom);
      // Remove the lowest and the highest value (each stored twice), a value that
      // is absent and the first of two equal values.
      issue(stid_pkg::OP_REMOVE, 32'sh8000_0000);
      issue(stid_pkg::OP_REMOVE, 32'sh7FFF_FFFF);
      issue(stid_pkg::OP_REMOVE, 32'sd12345);
      issue(stid_pkg::OP_REMOVE, 32'sd0);
      issue(stid_pkg::OP_READ_OUT, $urandom);
      // Clear must leave an empty table that then fills from the bottom.
      issue(stid_pkg::OP_CLEAR, $urandom);
      issue(stid_pkg::OP_READ_OUT, $urandom);
      issue(stid_pkg::OP_INSERT, -32'sd1);

      // Random part. It alternates between stretches that favour inserts, so
      // that the table often runs full, and stretches that favour removes.
      // Clear stays rare so that the table has time to fill.
      for (n = 0; n < 370; n++) begin
         idle_on = !(n >= 150 && n < 260);
         filling = ((n / 50) % 2) == 0;
         roll    = $urandom_range(0, 99);
         if (roll < (filling ? 60 : 25)) begin
            issue(stid_pkg::OP_INSERT, pick_value());
         end else if (roll < (filling ? 80 : 75)) begin
            if (recent_values.size() != 0 && $urandom_range(0, 9) < 6)
               value = recent_values[$urandom_range(0, recent_values.size() - 1)];
            else
               value = pick_value();
            issue(stid_pkg::OP_REMOVE, value);
         end else if (roll < 96) begin
            issue(stid_pkg::OP_READ_OUT, $urandom);
         end else begin
            issue(stid_pkg::OP_CLEAR, $urandom);
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // Wait for the last awaited result, then allow for a slow remove before
      // the verdict so that any stray result is still caught.
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
